>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL. They compile away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_SYNC(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_SYNC(lbl, clk, rst, prop, msg)

`define ASSERT_NORST(lbl, clk, prop, msg)

`endif

`endif

>>> hdl/shs_pkg.sv
package shs_pkg;

  localparam int DefDepth = 16;

  localparam int SampleW = 16;
  localparam int FillW   = 5;
  localparam int SumW    = 21;
  localparam int ModeW   = 2;
  localparam int CfgW    = 5;
  localparam int CfgIdxW = 1;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegMode   = 1'd0;
  localparam logic [CfgIdxW-1:0] RegWindow = 1'd1;

  localparam logic [ModeW-1:0] ModeRaw    = 2'd0;
  localparam logic [ModeW-1:0] ModeSmooth = 2'd1;
  localparam logic [ModeW-1:0] ModeMean   = 2'd2;

  localparam logic [CfgW-1:0] WindowReset = 5'd16;
  localparam logic [FillW-1:0] MinLen     = 5'd3;
  localparam int MaxLen = 31;

  // Job codes handed from the front to the back.
  localparam int OpW = 2;
  localparam logic [OpW-1:0] OpClear  = 2'd0;
  localparam logic [OpW-1:0] OpRaw    = 2'd1;
  localparam logic [OpW-1:0] OpSmooth = 2'd2;
  localparam logic [OpW-1:0] OpMean   = 2'd3;

  // Q0.16 coefficients of the recursive smoother.
  localparam logic signed [16:0] C035 = 17'sd22938;
  localparam logic signed [16:0] C015 = 17'sd9830;

  localparam int QDepth   = 2;
  localparam int DivSteps = SumW;

  typedef struct packed {
    logic                      func;
    logic signed [SampleW-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] newest;
    logic signed [SampleW-1:0] smoothed;
    logic [FillW-1:0]          fill_count;
    logic                      full_res;
  } out_item_t;

  typedef struct packed {
    logic [OpW-1:0]            op;
    logic signed [SampleW-1:0] sample;
  } job_t;

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [17:0] v);
    logic signed [SampleW-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/shs_front.sv
module shs_front #(
  parameter int Depth = shs_pkg::DefDepth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  shs_pkg::in_item_t              in_item,
  input  logic                           cfg_we,
  input  logic [shs_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [shs_pkg::CfgW-1:0]       cfg_data,
  output logic                           q_push,
  input  logic                           q_ready,
  output shs_pkg::job_t                  q_job,
  output logic [shs_pkg::FillW-1:0]      len
);

  localparam int LenMax = (Depth < shs_pkg::MaxLen) ? Depth : shs_pkg::MaxLen;
  localparam logic [shs_pkg::FillW-1:0] LenMaxV = shs_pkg::FillW'(LenMax);

  logic [shs_pkg::ModeW-1:0] mode;
  logic [shs_pkg::CfgW-1:0]  window;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= shs_pkg::ModeRaw;
      window <= shs_pkg::WindowReset;
    end else if (cfg_we) begin
      case (cfg_index)
        shs_pkg::RegMode:   mode   <= cfg_data[shs_pkg::ModeW-1:0];
        shs_pkg::RegWindow: window <= cfg_data;
        default: ;
      endcase
    end
  end

  // The window in use is clamped to at least MinLen and to what the history can hold.
  always_comb begin
    if (window < shs_pkg::MinLen) begin
      len = shs_pkg::MinLen;
    end else if (window > LenMaxV) begin
      len = LenMaxV;
    end else begin
      len = window;
    end
  end

  always_comb begin
    q_job.sample = in_item.sample;
    if (in_item.func) begin
      q_job.op = shs_pkg::OpClear;
    end else begin
      case (mode)
        shs_pkg::ModeSmooth: q_job.op = shs_pkg::OpSmooth;
        shs_pkg::ModeMean:   q_job.op = shs_pkg::OpMean;
        default:             q_job.op = shs_pkg::OpRaw;
      endcase
    end
  end

  assign q_push   = in_valid && q_ready;
  assign in_stall = !q_ready;

endmodule

>>> hdl/shs_queue.sv
`include "assert_macros.svh"

module shs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  shs_pkg::job_t push_job,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output shs_pkg::job_t pop_job
);

  localparam int PtrW = $clog2(shs_pkg::QDepth);
  localparam int CntW = $clog2(shs_pkg::QDepth + 1);

  shs_pkg::job_t    slots [shs_pkg::QDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign ready   = count < CntW'(shs_pkg::QDepth);
  assign valid   = count != '0;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(shs_pkg::QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(shs_pkg::QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_SYNC(a_pop_nonempty, clk, rst, pop |-> count != '0, "pop from empty job queue")
  `ASSERT_SYNC(a_push_room, clk, rst, push |-> ready, "push into full job queue")
  `ASSERT_SYNC(a_count_bound, clk, rst, count <= CntW'(shs_pkg::QDepth), "job queue overfilled")

endmodule

>>> hdl/shs_div.sv
module shs_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [shs_pkg::SumW-1:0]     dividend,
  input  logic [shs_pkg::FillW-1:0]           divisor,
  output logic                                busy,
  output logic                                done,
  output logic signed [shs_pkg::SampleW-1:0]  quotient
);

  localparam int SumW = shs_pkg::SumW;
  localparam int DW   = shs_pkg::FillW;
  localparam int CntW = $clog2(shs_pkg::DivSteps);

  logic [SumW-1:0] dvd;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dsr;
  logic            neg;
  logic [CntW-1:0] cnt;
  logic [DW:0]     trial;
  logic            fits;

  // One quotient bit per cycle, restoring form on the magnitude.
  assign trial = {rem, dvd[SumW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
      neg <= dividend[SumW-1];
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
      dvd <= {dvd[SumW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(shs_pkg::DivSteps - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // The magnitude can reach 2^20, so the signed result is clamped.
  always_comb begin
    if (!neg && dvd > SumW'(32767)) begin
      quotient = 16'sh7fff;
    end else if (neg && dvd > SumW'(32768)) begin
      quotient = 16'sh8000;
    end else if (neg) begin
      quotient = -$signed(dvd[shs_pkg::SampleW-1:0]);
    end else begin
      quotient = $signed(dvd[shs_pkg::SampleW-1:0]);
    end
  end

endmodule

>>> hdl/shs_back.sv
`include "assert_macros.svh"

module shs_back #(
  parameter int Depth = shs_pkg::DefDepth
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  shs_pkg::job_t              q_job,
  output logic                       q_pop,
  input  logic [shs_pkg::FillW-1:0]  len,
  output logic                       out_valid,
  input  logic                       out_stall,
  output shs_pkg::out_item_t         out_item
);

  localparam int SW   = shs_pkg::SampleW;
  localparam int FW   = shs_pkg::FillW;
  localparam int SumW = shs_pkg::SumW;
  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]                state;
  logic signed [SW-1:0]      hist [Depth];
  logic signed [SW-1:0]      raw  [Depth];
  logic [FW-1:0]             fill;
  logic signed [SumW-1:0]    wsum;
  logic                      skip;
  logic signed [SW-1:0]      s_r;
  logic signed [31:0]        p1;
  logic signed [31:0]        p2;

  logic [FW-1:0]             fill_inc;
  logic signed [SW-1:0]      leaving;
  logic signed [SumW-1:0]    sum_new;
  logic                      shift_en;
  logic                      clear_en;
  logic                      div_start;
  logic                      div_busy;
  logic                      div_done;
  logic signed [SW-1:0]      div_q;
  logic signed [33:0]        mix_acc;
  logic signed [SW-1:0]      mix_val;
  logic signed [18:0]        tap_acc;
  logic                      out_load;

  assign q_pop    = (state == StIdle) && q_valid;
  assign fill_inc = (fill < len) ? fill + 1'b1 : len;
  assign leaving  = raw[IdxW'(len - 1'b1)];

  // The sample leaving the window only counts once the window was full.
  always_comb begin
    sum_new = wsum + {{(SumW-SW){q_job.sample[SW-1]}}, q_job.sample};
    if (fill >= len) begin
      sum_new = sum_new - {{(SumW-SW){leaving[SW-1]}}, leaving};
    end
  end

  always_comb begin
    clear_en  = q_pop && (q_job.op == shs_pkg::OpClear);
    shift_en  = q_pop && ((q_job.op == shs_pkg::OpRaw) ||
                          (q_job.op == shs_pkg::OpSmooth) ||
                          ((q_job.op == shs_pkg::OpMean) && !skip));
    div_start = q_pop && (q_job.op == shs_pkg::OpMean) && !skip;
  end

  // Round half up: add one half before the floor shift.
  assign mix_acc = {{3{s_r[SW-1]}}, s_r, 15'd0} + 34'(p1) + 34'(p2) + 34'sd32768;
  assign mix_val = shs_pkg::sat16(mix_acc[33:16]);

  assign tap_acc = 19'(hist[0]) + 19'(hist[0]) + 19'(hist[1]) + 19'(hist[2]) + 19'sd2;
  assign out_load = (state == StDone) && (!out_valid || !out_stall);

  shs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (fill_inc),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst || clear_en) begin
      for (int i = 0; i < Depth; i++) begin
        hist[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = 1; i < Depth; i++) begin
        if (i < int'(len)) begin
          hist[i] <= hist[i-1];
        end
      end
      hist[0] <= q_job.sample;
    end else if (state == StSum) begin
      hist[0] <= mix_val;
    end else if ((state == StDiv) && div_done) begin
      hist[0] <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 1; i < Depth; i++) begin
        if (i < int'(len)) begin
          raw[i] <= raw[i-1];
        end
      end
      raw[0] <= q_job.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (state == StMul) begin
      p1 <= hist[1] * shs_pkg::C035;
      p2 <= hist[2] * shs_pkg::C015;
    end
    if (q_pop) begin
      s_r <= q_job.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      fill  <= '0;
      wsum  <= '0;
      skip  <= 1'b1;
    end else begin
      case (state)
        StIdle: begin
          if (q_valid) begin
            state <= StDone;
            case (q_job.op)
              shs_pkg::OpClear: begin
                fill <= '0;
                wsum <= '0;
                skip <= 1'b1;
              end
              shs_pkg::OpRaw: begin
                fill <= fill_inc;
              end
              shs_pkg::OpSmooth: begin
                fill <= fill_inc;
                if (fill_inc >= shs_pkg::MinLen) begin
                  state <= StMul;
                end
              end
              shs_pkg::OpMean: begin
                if (skip) begin
                  skip <= 1'b0;
                end else begin
                  fill  <= fill_inc;
                  wsum  <= sum_new;
                  state <= StDiv;
                end
              end
              default: ;
            endcase
          end
        end
        StMul:  state <= StSum;
        StSum:  state <= StDone;
        StDiv: begin
          if (div_done) begin
            state <= StDone;
          end
        end
        StDone: begin
          if (out_load) begin
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item.newest     <= hist[0];
      out_item.smoothed   <= shs_pkg::sat16(18'($signed(tap_acc[18:2])));
      out_item.fill_count <= fill;
      out_item.full_res   <= fill >= len;
    end
  end

  `ASSERT_SYNC(a_div_done_state, clk, rst, div_done |-> state == StDiv, "divider done off step")
  `ASSERT_SYNC(a_idle_div_quiet, clk, rst, state == StIdle |-> !div_busy, "divider busy in idle")
  `ASSERT_SYNC(a_mul_then_sum, clk, rst, state == StMul |=> state == StSum, "multiply without sum")

endmodule

>>> hdl/sample_history_smoother_unit.sv
// Sample history smoother.
// Input channel: in_valid / in_stall / in_item (func, sample). A beat is taken
// when in_valid is high and in_stall is low. func = 1 clears the history,
// fill count, window sum and sets the mean step to drop the next sample.
// Output channel: out_valid / out_stall / out_item, one beat per input beat,
// in order. Configuration: cfg_we, cfg_index, cfg_data; index 0 is the mode,
// index 1 the window length. Write them only while no beat is in flight.
// A two-entry job queue sits between the front (config, decode) and the
// back (history, arithmetic), so up to two input beats are taken while the
// back is busy or the output is stalled.
// From accept to output beat, raw store, clear and a dropped mean sample go
// from idle straight to the final step; recursive smoothing passes the
// multiply and sum steps once the fill reaches MinLen, and the running mean
// waits on the divider, which yields one quotient bit per cycle.
// A stalled output beat holds; the back waits in its final step until the
// output register is free. Reset (rst, synchronous) empties the queue,
// clears the history, count and sum, and restores mode 0 and window 16.
module sample_history_smoother_unit #(
  parameter int Depth = shs_pkg::DefDepth
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  shs_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output shs_pkg::out_item_t           out_item,
  input  logic                         cfg_we,
  input  logic [shs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [shs_pkg::CfgW-1:0]     cfg_data
);

  logic                      q_push;
  logic                      q_ready;
  logic                      q_valid;
  logic                      q_pop;
  shs_pkg::job_t             push_job;
  shs_pkg::job_t             pop_job;
  logic [shs_pkg::FillW-1:0] len;

  shs_front #(.Depth(Depth)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_job     (push_job),
    .len       (len)
  );

  shs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (pop_job)
  );

  shs_back #(.Depth(Depth)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .len       (len),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
